@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL of the record sorter.
// Depends on nothing; the user supplies clock, reset and the label.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BSR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/bsr_pkg.sv @@
// Package of the record sorter: widths, control word type and microcode ROM.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bsr_pkg;

   localparam int MAX_ITEMS_DEF = 64;
   localparam int KEY_W         = 16;
   localparam int PAY_W         = 16;
   localparam int REC_W         = KEY_W + PAY_W;
   localparam int STEP_W        = 3;

   typedef logic [STEP_W-1:0] step_type;

   // microcode step addresses
   localparam step_type STEP_LOAD      = 3'd0;
   localparam step_type STEP_INIT      = 3'd1;
   localparam step_type STEP_PASS      = 3'd2;
   localparam step_type STEP_FIRST     = 3'd3;
   localparam step_type STEP_CMP       = 3'd4;
   localparam step_type STEP_TAIL      = 3'd5;
   localparam step_type STEP_EMIT_RD   = 3'd6;
   localparam step_type STEP_EMIT_SEND = 3'd7;

   typedef enum logic [1:0] {HOLD_NONE, HOLD_REQ, HOLD_OUT} hold_type;
   typedef enum logic [1:0] {RD_NONE, RD_ZERO, RD_NEXT, RD_EMIT} rd_src_type;
   typedef enum logic [1:0] {WR_NONE, WR_REQ, WR_CMP, WR_TAIL} wr_src_type;
   typedef enum logic [1:0] {CUR_HOLD, CUR_LOAD, CUR_CMP} cur_op_type;
   typedef enum logic [1:0] {CNT_HOLD, CNT_CLR, CNT_INC} cnt_op_type;
   typedef enum logic [1:0] {LIM_HOLD, LIM_INIT, LIM_DEC} lim_op_type;
   typedef enum logic [2:0] {
      COND_NEVER, COND_LAST, COND_SMALL, COND_PASS_DONE, COND_LIM_ONE, COND_EMIT_DONE
   } cond_type;

   typedef struct packed {
      hold_type   hold_on;
      rd_src_type rd_src;
      wr_src_type wr_src;
      cur_op_type cur_op;
      cnt_op_type j_op;
      lim_op_type lim_op;
      cnt_op_type k_op;
      logic       emit;
      cond_type   cond;
      step_type   tgt_true;
      step_type   tgt_false;
   } ctrl_word_type;

   localparam ctrl_word_type CW_NOP = '{
      hold_on: HOLD_NONE, rd_src: RD_NONE, wr_src: WR_NONE, cur_op: CUR_HOLD,
      j_op: CNT_HOLD, lim_op: LIM_HOLD, k_op: CNT_HOLD, emit: 1'b0,
      cond: COND_NEVER, tgt_true: STEP_LOAD, tgt_false: STEP_LOAD
   };

   // Microprogram: load, n-1 bubble passes carrying the larger record, emit.
   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type cw;
      cw = CW_NOP;
      case (step)
         STEP_LOAD: begin
            cw.hold_on   = HOLD_REQ;
            cw.wr_src    = WR_REQ;
            cw.cond      = COND_LAST;
            cw.tgt_true  = STEP_INIT;
            cw.tgt_false = STEP_LOAD;
         end
         STEP_INIT: begin
            cw.lim_op    = LIM_INIT;
            cw.k_op      = CNT_CLR;
            cw.cond      = COND_SMALL;
            cw.tgt_true  = STEP_EMIT_RD;
            cw.tgt_false = STEP_PASS;
         end
         STEP_PASS: begin
            cw.rd_src    = RD_ZERO;
            cw.j_op      = CNT_CLR;
            cw.tgt_false = STEP_FIRST;
         end
         STEP_FIRST: begin
            cw.cur_op    = CUR_LOAD;
            cw.rd_src    = RD_NEXT;
            cw.tgt_false = STEP_CMP;
         end
         STEP_CMP: begin
            cw.cur_op    = CUR_CMP;
            cw.wr_src    = WR_CMP;
            cw.rd_src    = RD_NEXT;
            cw.j_op      = CNT_INC;
            cw.cond      = COND_PASS_DONE;
            cw.tgt_true  = STEP_TAIL;
            cw.tgt_false = STEP_CMP;
         end
         STEP_TAIL: begin
            cw.wr_src    = WR_TAIL;
            cw.lim_op    = LIM_DEC;
            cw.cond      = COND_LIM_ONE;
            cw.tgt_true  = STEP_EMIT_RD;
            cw.tgt_false = STEP_PASS;
         end
         STEP_EMIT_RD: begin
            cw.rd_src    = RD_EMIT;
            cw.tgt_false = STEP_EMIT_SEND;
         end
         STEP_EMIT_SEND: begin
            cw.hold_on   = HOLD_OUT;
            cw.emit      = 1'b1;
            cw.k_op      = CNT_INC;
            cw.cond      = COND_EMIT_DONE;
            cw.tgt_true  = STEP_LOAD;
            cw.tgt_false = STEP_EMIT_RD;
         end
         default: cw = CW_NOP;
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

@@ design/bubble_sort_records_by_key.sv @@
// Record sorter: loads up to MAX_ITEMS records, bubble sorts them by key, emits them in order.
// Loading takes one item per cycle. After the last item: a setup step, then per pass over L+1
// entries: PASS, FIRST, a CMP per compare, TAIL; then a read and a send step per record.
// The one read and one write port of the record store bound every phase.
// The output register lets the next set load while the final record waits.
// Reset (synchronous, active high) clears the step counter, record count and output valid.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bubble_sort_records_by_key #(
   parameter int MAX_ITEMS = bsr_pkg::MAX_ITEMS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_ready,
   input  wire logic [bsr_pkg::KEY_W-1:0] req_key,
   input  wire logic [bsr_pkg::PAY_W-1:0] req_payload,
   input  wire logic                      req_last_in,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   output      logic [bsr_pkg::KEY_W-1:0] rsp_sorted_key,
   output      logic [bsr_pkg::PAY_W-1:0] rsp_sorted_payload,
   output      logic                      rsp_last_out
);

   localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int REC_W = bsr_pkg::REC_W;
   localparam int KEY_W = bsr_pkg::KEY_W;
   localparam int PAY_W = bsr_pkg::PAY_W;

   // ---------------------------------------------------------------- sequencer
   bsr_pkg::step_type      step_ff, step_in;
   bsr_pkg::ctrl_word_type cw;
   logic                   go;         // step's wait condition met, effects fire
   logic                   cond_true;
   logic                   out_free;

   // ---------------------------------------------------------------- datapath
   logic [CNT_W-1:0] count_ff, count_in;   // records held
   logic [CNT_W-1:0] j_ff, j_in;           // left index of the current compare
   logic [CNT_W-1:0] lim_ff, lim_in;       // last index of the current pass
   logic [CNT_W-1:0] k_ff, k_in;           // emit index
   logic [REC_W-1:0] cur_ff, cur_in;       // record carried along a pass
   logic [REC_W-1:0] rd_data_ff;           // registered store read
   logic [REC_W-1:0] store_ff [MAX_ITEMS];

   logic             rd_en;
   logic [CNT_W-1:0] rd_addr;
   logic             wr_en;
   logic [CNT_W-1:0] wr_addr;
   logic [REC_W-1:0] wr_data;
   logic             left_ge;              // carried key >= fetched key: swap
   logic             room;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0] rsp_key_ff;
   logic [PAY_W-1:0] rsp_pay_ff;
   logic             rsp_last_ff;

   assign cw       = bsr_pkg::ucode_rom(step_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign room     = count_ff < CNT_W'(MAX_ITEMS);
   assign left_ge  = cur_ff[REC_W-1 -: KEY_W] >= rd_data_ff[REC_W-1 -: KEY_W];

   // the only step that takes items is the load step
   assign req_ready = (cw.hold_on == bsr_pkg::HOLD_REQ);

   always_comb begin
      case (cw.hold_on)
         bsr_pkg::HOLD_REQ: go = req_valid;
         bsr_pkg::HOLD_OUT: go = out_free;
         default:           go = 1'b1;
      endcase
   end

   always_comb begin
      case (cw.cond)
         bsr_pkg::COND_LAST:      cond_true = req_last_in;
         bsr_pkg::COND_SMALL:     cond_true = count_ff < CNT_W'(2);
         bsr_pkg::COND_PASS_DONE: cond_true = (j_ff + CNT_W'(1)) == lim_ff;
         bsr_pkg::COND_LIM_ONE:   cond_true = lim_ff == CNT_W'(1);
         bsr_pkg::COND_EMIT_DONE: cond_true = (k_ff + CNT_W'(1)) == count_ff;
         default:                 cond_true = 1'b0;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (go) begin
         step_in = cond_true ? cw.tgt_true : cw.tgt_false;
      end
   end

   // index counters
   always_comb begin
      j_in   = j_ff;
      lim_in = lim_ff;
      k_in   = k_ff;
      if (go) begin
         case (cw.j_op)
            bsr_pkg::CNT_CLR: j_in = '0;
            bsr_pkg::CNT_INC: j_in = j_ff + CNT_W'(1);
            default:          j_in = j_ff;
         endcase
         case (cw.lim_op)
            bsr_pkg::LIM_INIT: lim_in = count_ff - CNT_W'(1);
            bsr_pkg::LIM_DEC:  lim_in = lim_ff - CNT_W'(1);
            default:           lim_in = lim_ff;
         endcase
         case (cw.k_op)
            bsr_pkg::CNT_CLR: k_in = '0;
            bsr_pkg::CNT_INC: k_in = k_ff + CNT_W'(1);
            default:          k_in = k_ff;
         endcase
      end
   end

   // carried record: the larger (or the carried one on a tie) moves on
   always_comb begin
      cur_in = cur_ff;
      if (go) begin
         case (cw.cur_op)
            bsr_pkg::CUR_LOAD: cur_in = rd_data_ff;
            bsr_pkg::CUR_CMP:  cur_in = left_ge ? cur_ff : rd_data_ff;
            default:           cur_in = cur_ff;
         endcase
      end
   end

   // store read port; a next read uses the updated j so it runs one ahead
   always_comb begin
      rd_en   = go && (cw.rd_src != bsr_pkg::RD_NONE);
      case (cw.rd_src)
         bsr_pkg::RD_NEXT: rd_addr = j_in + CNT_W'(1);
         bsr_pkg::RD_EMIT: rd_addr = k_ff;
         default:          rd_addr = '0;
      endcase
   end

   // store write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff;
      wr_data = {req_key, req_payload};
      case (cw.wr_src)
         bsr_pkg::WR_REQ: begin
            wr_en   = go && room;
            wr_addr = count_ff;
            wr_data = {req_key, req_payload};
         end
         bsr_pkg::WR_CMP: begin
            wr_en   = go;
            wr_addr = j_ff;
            wr_data = left_ge ? rd_data_ff : cur_ff;
         end
         bsr_pkg::WR_TAIL: begin
            wr_en   = go;
            wr_addr = lim_ff;
            wr_data = cur_ff;
         end
         default: begin
            wr_en   = 1'b0;
         end
      endcase
   end

   // record count: grows while loading, cleared once the final record is out
   always_comb begin
      count_in = count_ff;
      if ((cw.wr_src == bsr_pkg::WR_REQ) && go && room) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cw.emit && go && cond_true) begin
         count_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cw.emit && go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= bsr_pkg::STEP_LOAD;
         count_ff     <= '0;
         j_ff         <= '0;
         lim_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         count_ff     <= count_in;
         j_ff         <= j_in;
         lim_ff       <= lim_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (cw.emit && go) begin
         rsp_key_ff  <= rd_data_ff[REC_W-1 -: KEY_W];
         rsp_pay_ff  <= rd_data_ff[PAY_W-1:0];
         rsp_last_ff <= cond_true;
      end
   end

   // record store: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr[IDX_W-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr[IDX_W-1:0]];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sorted_key     = rsp_key_ff;
   assign rsp_sorted_payload = rsp_pay_ff;
   assign rsp_last_out       = rsp_last_ff;

   // ---------------------------------------------------------------- checks
   `BSR_ASSERT_NEXT(a_last_starts_sort, clock, reset, req_valid && req_ready && req_last_in, step_ff == bsr_pkg::STEP_INIT, "last item did not start the sort")
   `BSR_ASSERT_NOW(a_busy_has_records, clock, reset, step_ff != bsr_pkg::STEP_LOAD, count_ff != '0, "sorting or emitting with no records")
   `BSR_ASSERT_NOW(a_cmp_in_range, clock, reset, step_ff == bsr_pkg::STEP_CMP, (j_ff < lim_ff) && (lim_ff < count_ff), "compare index outside pass range")
   `BSR_ASSERT_NEXT(a_final_clears, clock, reset, cw.emit && go && cond_true, (count_ff == '0) && (step_ff == bsr_pkg::STEP_LOAD) && rsp_last_out, "final record did not end the set")

endmodule

`default_nettype wire

@@ tb/bubble_sort_records_by_key_test.sv @@
// Self-checking bench for the record sorter: sets of records go in, sorted runs come out.
// Needs bsr_pkg and bubble_sort_records_by_key; the predictor is a plain bubble sort here.
`timescale 1ns / 1ps

module bubble_sort_records_by_key_test;

   localparam int STORE_CAP    = bsr_pkg::MAX_ITEMS_DEF;
   localparam int ITEMS_TOTAL  = 420;   // rough stimulus length
   localparam int CALM_TAIL    = 60;    // last items run with no idling on either side
   localparam int STALL_LIMIT  = 12000; // cycles with no handshake before giving up
   localparam int DRAIN_CYCLES = 100;   // settle time once nothing is expected
   localparam int MAX_REPORTS  = 10;
   localparam int DIRECTED_ROWS = 23;

   typedef logic [bsr_pkg::KEY_W-1:0] key_type;
   typedef logic [bsr_pkg::PAY_W-1:0] payload_type;

   typedef struct packed {
      key_type     key;
      payload_type payload;
   } record_type;

   typedef struct packed {
      key_type     key;
      payload_type payload;
      logic        last;
   } sorted_rec_type;

   // One row of the directed table. Where typed is set the row is a one-record set
   // and its result is written out here rather than predicted.
   typedef struct packed {
      key_type     key;
      payload_type payload;
      logic        last;
      logic        typed;
      key_type     exp_key;
      payload_type exp_payload;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   key_type     req_key = '0;
   payload_type req_payload = '0;
   logic        req_last_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   key_type     rsp_sorted_key;
   payload_type rsp_sorted_payload;
   logic        rsp_last_out;

   // Records of the set being loaded, and sorted records still to come back.
   record_type     loading_set[$];
   sorted_rec_type pending_sorted[$];

   int  items_sent = 0;
   int  sets_sent = 0;
   int  overflow_sets = 0;
   int  results_checked = 0;
   int  mismatches = 0;
   int  quiet_cycles = 0;
   bit  calm = 1'b0;        // end of run: no idling
   bit  rsp_stall_on = 1'b1;
   int  rsp_stall_left = 0;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // single records straight after reset: both extremes and a middle value
      '{16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0000, 16'h0000},
      '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF},
      '{16'h1234, 16'hABCD, 1'b1, 1'b1, 16'h1234, 16'hABCD},
      // strictly descending
      '{16'hFFFF, 16'h0001, 1'b0, 1'b0, 16'h0000, 16'h0000},
      '{16'h8000, 16'h0002, 1'b0, 1'b0, 16'h0000, 16'h0000},
      '{16'h0001, 16'h0003, 1'b0, 1'b0, 16'h0000, 16'h0000},
      '{16'h0000, 16'h0004, 1'b1, 1'b0, 16'h0000, 16'h0000},
      // already ascending
      '{16'h0000, 16'h0010, 1'b0, 1'b0, 16'h0000, 16'h0000},
      '{16'h0001, 16'h0011, 1'b0, 1'b0, 16'h0000, 16'h0000},
      '{16'h7FFF, 16'h0012, 1'b0, 1'b0, 16'h0000, 16'h0000},
      '{16'hFFFF, 16'h0013, 1'b1, 1'b0, 16'h0000, 16'h0000},
      // all keys equal: payload order shows the tie rule
      '{16'h0005, 16'h0A00, 1'b0, 1'b0, 16'h0000, 16'h0000},
      '{16'h0005, 16'h0A01, 1'b0, 1'b0, 16'h0000, 16'h0000},
      '{16'h0005, 16'h0A02, 1'b0, 1'b0, 16'h0000, 16'h0000},
      '{16'h0005, 16'h0A03, 1'b1, 1'b0, 16'h0000, 16'h0000},
      // interleaved ties
      '{16'h0009, 16'h00B0, 1'b0, 1'b0, 16'h0000, 16'h0000},
      '{16'h0002, 16'h00B1, 1'b0, 1'b0, 16'h0000, 16'h0000},
      '{16'h0009, 16'h00B2, 1'b0, 1'b0, 16'h0000, 16'h0000},
      '{16'h0002, 16'h00B3, 1'b0, 1'b0, 16'h0000, 16'h0000},
      '{16'hFFFF, 16'h00B4, 1'b1, 1'b0, 16'h0000, 16'h0000},
      // pair of equal top keys
      '{16'hFFFF, 16'h5555, 1'b0, 1'b0, 16'h0000, 16'h0000},
      '{16'hFFFF, 16'hAAAA, 1'b1, 1'b0, 16'h0000, 16'h0000},
      // one more lone record
      '{16'hAAAA, 16'h5555, 1'b1, 1'b1, 16'hAAAA, 16'h5555}
   };

   bubble_sort_records_by_key dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_key            (req_key),
      .req_payload        (req_payload),
      .req_last_in        (req_last_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sorted_key     (rsp_sorted_key),
      .rsp_sorted_payload (rsp_sorted_payload),
      .rsp_last_out       (rsp_last_out)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor. Records beyond the store capacity are dropped; a last item sorts
   // what is held with n-1 passes, swapping on left key >= right key, so equal
   // keys trade places on every compare that reaches them.
   function automatic void take_record(input key_type k, input payload_type p, input logic l);
      record_type     swap_tmp;
      sorted_rec_type out_rec;
      int             n;
      if (loading_set.size() < STORE_CAP) loading_set.push_back('{k, p});
      if (!l) return;
      n = loading_set.size();
      for (int pass = 0; pass < n - 1; pass++) begin
         for (int j = 0; j + 1 < n - pass; j++) begin
            if (loading_set[j].key >= loading_set[j+1].key) begin
               swap_tmp         = loading_set[j];
               loading_set[j]   = loading_set[j+1];
               loading_set[j+1] = swap_tmp;
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         out_rec.key     = loading_set[i].key;
         out_rec.payload = loading_set[i].payload;
         out_rec.last    = (i == n - 1);
         pending_sorted.push_back(out_rec);
      end
      loading_set.delete();
   endfunction

   // Drive one item and return at the edge that takes it. Called just after an edge,
   // so valid stays high straight into the next item when no gap follows.
   task automatic send_item(input key_type k, input payload_type p, input logic l);
      req_valid   <= 1'b1;
      req_key     <= k;
      req_payload <= p;
      req_last_in <= l;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (l) sets_sent++;
   endtask

   // Sender gap of random length, taken with the given chance.
   task automatic maybe_pause(input int gap_pct);
      int gap_len;
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         gap_len = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap_len) @(posedge clock);
      end
   endtask

   // Keys lean towards extremes and a tiny range so ties turn up often.
   function automatic key_type pick_key();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         2, 3, 4: begin
            return key_type'($urandom_range(0, 3));
         end
         default: begin
            return key_type'($urandom_range(0, 65535));
         end
      endcase
   endfunction

   // Receiver: ready drops in bursts of random length; bursts switch on and off
   // now and then so there are stretches with none.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= 0;
      end else if (rsp_stall_left != 0) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (!calm && rsp_stall_on && $urandom_range(0, 99) < 15) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_ready <= 1'b1;
      end
      if ($urandom_range(0, 199) == 0) rsp_stall_on <= !rsp_stall_on;
   end

   // Result checker and watchdog. Outputs are read at the edge, before any update.
   always @(posedge clock) begin
      sorted_rec_type exp_rec;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_sorted.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("Unexpected result: key %h payload %h last %b, none pending",
                           rsp_sorted_key, rsp_sorted_payload, rsp_last_out);
            end else begin
               exp_rec = pending_sorted.pop_front();
               results_checked++;
               if (rsp_sorted_key !== exp_rec.key || rsp_sorted_payload !== exp_rec.payload ||
                   rsp_last_out !== exp_rec.last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("Result %0d: expected key %h payload %h last %b, got %h %h %b",
                              results_checked, exp_rec.key, exp_rec.payload, exp_rec.last,
                              rsp_sorted_key, rsp_sorted_payload, rsp_last_out);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      int  set_len;
      int  gap_pct;
      int  sel;
      bit  first_random;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table. Typed rows are lone records after a set boundary, so the
      // loading set is empty and their one result can be queued directly.
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         maybe_pause(25);
         send_item(directed_rows[r].key, directed_rows[r].payload, directed_rows[r].last);
         if (directed_rows[r].typed)
            pending_sorted.push_back('{directed_rows[r].exp_key,
                                       directed_rows[r].exp_payload, 1'b1});
         else
            take_record(directed_rows[r].key, directed_rows[r].payload,
                        directed_rows[r].last);
      end

      // Hold off until every directed result is back.
      req_valid <= 1'b0;
      while (pending_sorted.size() != 0) @(posedge clock);

      // Random sets: mostly short, some medium, a few that fill or overrun the store
      // (last item then lands on a dropped record or exactly on the final slot).
      first_random = 1'b1;
      while (items_sent < ITEMS_TOTAL) begin
         sel = $urandom_range(0, 99);
         if (first_random || sel < 6) set_len = $urandom_range(STORE_CAP, STORE_CAP + 4);
         else if (sel < 22) set_len = $urandom_range(9, 40);
         else set_len = $urandom_range(1, 8);
         first_random = 1'b0;
         if (set_len > STORE_CAP) overflow_sets++;
         case ($urandom_range(0, 2))
            0: begin
               gap_pct = 0;
            end
            1: begin
               gap_pct = 15;
            end
            default: begin
               gap_pct = 40;
            end
         endcase
         for (int i = 0; i < set_len; i++) begin
            key_type     k;
            payload_type p;
            k = pick_key();
            p = payload_type'($urandom_range(0, 65535));
            if (items_sent >= ITEMS_TOTAL - CALM_TAIL) calm = 1'b1;
            maybe_pause(gap_pct);
            send_item(k, p, i == set_len - 1);
            take_record(k, p, i == set_len - 1);
         end
      end
      req_valid <= 1'b0;

      while (pending_sorted.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d items in %0d sets (%0d past store capacity), %0d results checked.",
               items_sent, sets_sent, overflow_sets, results_checked);
      if (mismatches == 0 && pending_sorted.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, pending_sorted.size());
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+design
design/bsr_pkg.sv
design/bubble_sort_records_by_key.sv
tb/bubble_sort_records_by_key_test.sv
